// ===== hw/rtl/msd_pkg.sv =====
// Shared types for the descending merge sort unit.
`timescale 1ns / 1ps

package msd_pkg;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_PASS,
		ST_RUN,
		ST_MERGE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} msd_state_t;

	// Memory control from the sequencer.
	typedef struct packed {
		logic we_a;   // write the value store
		logic we_b;   // write the merge scratch store
		logic src_b;  // scratch store is the current read source
	} msd_mem_ctl_t;

endpackage

// ===== hw/rtl/msd_in_if.sv =====
// Input channel: one value per beat with an end-of-set flag.
`timescale 1ns / 1ps

interface msd_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// ===== hw/rtl/msd_out_if.sv =====
// Output channel: one sorted value per beat with a final flag.
`timescale 1ns / 1ps

interface msd_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sorted_value;
	logic                         final_res;

	modport source (output valid, output sorted_value, output final_res, input ready);
	modport sink (input valid, input sorted_value, input final_res, output ready);
endinterface

// ===== hw/rtl/msd_mem.sv =====
// Synchronous memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module msd_mem #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [AW-1:0]         rd_addr0,
	input  logic [AW-1:0]         rd_addr1,
	output logic [DATA_WIDTH-1:0] rd_data0,
	output logic [DATA_WIDTH-1:0] rd_data1
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

// ===== hw/rtl/msd_engine.sv =====
// Sequencer: collects a set, runs bottom-up merge passes, emits the result.
`timescale 1ns / 1ps

module msd_engine import msd_pkg::*; #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	msd_in_if.sink                      items,
	msd_out_if.source                   results,
	input  logic [DATA_WIDTH-1:0]       rd_l,
	input  logic [DATA_WIDTH-1:0]       rd_r,
	output logic [$clog2(MAX_ITEMS)-1:0] rd_addr_l,
	output logic [$clog2(MAX_ITEMS)-1:0] rd_addr_r,
	output logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
	output logic [DATA_WIDTH-1:0]       wr_data,
	output msd_mem_ctl_t                ctl
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int EW = CW + 1;

	msd_state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [EW-1:0] w_q, lo_q;
	logic [CW-1:0] l_q, r_q, o_q, mid_q, hi_q, k_q;
	logic          parity_q;
	logic          out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic          out_final_q;

	logic          accept, store_ok, slot_free, load;
	logic [EW:0]   n2, sum1, sum2;
	logic [CW-1:0] mid_c, hi_c, l_n, r_n, o_inc, k_inc;
	logic          take_r, run_done, more_runs, k_last;

	assign accept    = items.valid && items.ready;
	assign store_ok  = cnt_q < CW'(MAX_ITEMS);
	assign slot_free = !out_valid_q || results.ready;

	// run bounds, clipped to the set size
	assign n2    = {2'b00, cnt_q};
	assign sum1  = {1'b0, lo_q} + {1'b0, w_q};
	assign sum2  = {1'b0, lo_q} + {w_q, 1'b0};
	assign mid_c = (sum1 > n2) ? cnt_q : sum1[CW-1:0];
	assign hi_c  = (sum2 > n2) ? cnt_q : sum2[CW-1:0];
	assign more_runs = sum2 < n2;

	// merge decision; equal values keep the left run first
	assign take_r = (r_q < hi_q) &&
		((l_q >= mid_q) || ($signed(rd_r) > $signed(rd_l)));
	assign l_n      = take_r ? l_q : l_q + CW'(1);
	assign r_n      = take_r ? r_q + CW'(1) : r_q;
	assign o_inc    = o_q + CW'(1);
	assign run_done = o_inc == hi_q;

	assign k_inc  = k_q + CW'(1);
	assign k_last = k_inc == cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (accept && items.last) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				state_d = (w_q < n2[EW-1:0]) ? ST_RUN : ST_EMIT_RD;
			end
			ST_RUN: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (run_done) begin
					state_d = more_runs ? ST_RUN : ST_PASS;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (slot_free) begin
					state_d = k_last ? ST_COLLECT : ST_EMIT_RD;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	// outputs
	always_comb begin
		items.ready = 1'b0;
		rd_addr_l   = k_q[AW-1:0];
		rd_addr_r   = k_q[AW-1:0];
		wr_addr     = cnt_q[AW-1:0];
		wr_data     = items.value;
		ctl.we_a    = 1'b0;
		ctl.we_b    = 1'b0;
		ctl.src_b   = parity_q;
		load        = 1'b0;
		case (state_q)
			ST_COLLECT: begin
				items.ready = 1'b1;
				ctl.we_a    = items.valid && store_ok;
			end
			ST_RUN: begin
				rd_addr_l = lo_q[AW-1:0];
				rd_addr_r = mid_c[AW-1:0];
			end
			ST_MERGE: begin
				rd_addr_l = l_n[AW-1:0];
				rd_addr_r = r_n[AW-1:0];
				wr_addr   = o_q[AW-1:0];
				wr_data   = take_r ? rd_r : rd_l;
				ctl.we_a  = parity_q;
				ctl.we_b  = !parity_q;
			end
			ST_EMIT_LD: begin
				load = slot_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			cnt_q       <= '0;
			w_q         <= '0;
			lo_q        <= '0;
			parity_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_COLLECT: begin
					if (accept && store_ok) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (accept && items.last) begin
						w_q      <= EW'(1);
						lo_q     <= '0;
						parity_q <= 1'b0;
						k_q      <= '0;
					end
				end
				ST_PASS: begin
					lo_q <= '0;
				end
				ST_MERGE: begin
					if (run_done) begin
						if (more_runs) begin
							lo_q <= sum2[EW-1:0];
						end else begin
							w_q      <= {w_q[EW-2:0], 1'b0};
							parity_q <= !parity_q;
						end
					end
				end
				ST_EMIT_LD: begin
					if (slot_free) begin
						k_q <= k_inc;
						if (k_last) begin
							cnt_q <= '0;
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// merge pointers and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			l_q   <= lo_q[CW-1:0];
			r_q   <= mid_c;
			o_q   <= lo_q[CW-1:0];
			mid_q <= mid_c;
			hi_q  <= hi_c;
		end else if (state_q == ST_MERGE) begin
			l_q <= l_n;
			r_q <= r_n;
			o_q <= o_inc;
		end
		if (load) begin
			out_data_q  <= rd_l;
			out_final_q <= k_last;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_data_q;
	assign results.final_res    = out_final_q;

endmodule

// ===== hw/rtl/merge_sort_descending_unit.sv =====
// Top level of the descending merge sort unit.
// Collect: one input beat per cycle, no result until the beat flagged last.
// Sort: ceil(log2(n)) merge passes; the pace of each pass is set by the single
// write port of the destination memory.
// Emit: each result is a memory read, then an output register load.
// Reset clears the sequencer and output valid; memory contents stay undefined.
`timescale 1ns / 1ps

module merge_sort_descending_unit import msd_pkg::*; #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	msd_in_if.sink    items,
	msd_out_if.source results
);

	localparam int AW = $clog2(MAX_ITEMS);

	msd_mem_ctl_t          ctl;
	logic [AW-1:0]         rd_addr_l, rd_addr_r, wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [DATA_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
	logic [DATA_WIDTH-1:0] rd_l, rd_r;

	// Value store: filled in arrival order, source of the first pass.
	msd_mem #(
		.DEPTH      (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_store (
		.clk      (clk),
		.we       (ctl.we_a),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr0 (rd_addr_l),
		.rd_addr1 (rd_addr_r),
		.rd_data0 (a_rd0),
		.rd_data1 (a_rd1)
	);

	// Scratch store: passes ping-pong between the two memories.
	msd_mem #(
		.DEPTH      (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_scratch (
		.clk      (clk),
		.we       (ctl.we_b),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr0 (rd_addr_l),
		.rd_addr1 (rd_addr_r),
		.rd_data0 (b_rd0),
		.rd_data1 (b_rd1)
	);

	// Select the current source memory; port 0 follows the left run head,
	// port 1 the right run head.
	assign rd_l = ctl.src_b ? b_rd0 : a_rd0;
	assign rd_r = ctl.src_b ? b_rd1 : a_rd1;

	msd_engine #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.results   (results),
		.rd_l      (rd_l),
		.rd_r      (rd_r),
		.rd_addr_l (rd_addr_l),
		.rd_addr_r (rd_addr_r),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.ctl       (ctl)
	);

	// A pass writes exactly one memory.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.we_a && ctl.we_b))
		else $error("both memories written in one cycle");

	// The scratch store is written only while merging, never while collecting.
	a_scratch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.we_b |-> !items.ready)
		else $error("scratch write while input is open");

	// A merge into the value store must read from the scratch store.
	a_pingpong: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.we_a && !items.ready) |-> ctl.src_b)
		else $error("merge reads and writes the same memory");

endmodule

// ===== bench/msd_sort_checker.sv =====
// Watches both channels of the sort unit, predicts each sorted set and compares.
`timescale 1ns / 1ps

module msd_sort_checker #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] in_value,
	input  logic                         in_last,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic signed [DATA_WIDTH-1:0] sorted_value,
	input  logic                         final_res,
	output int                           mismatches,
	output int                           outstanding
);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         is_final;
	} sorted_beat_t;

	logic signed [DATA_WIDTH-1:0] set_values[MAX_ITEMS];
	int                           set_count;
	sorted_beat_t                 expected_sorted[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		set_count   = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Bottom-up merge of the collected set, largest first; ties keep the left run.
	task automatic queue_sorted_set();
		logic signed [DATA_WIDTH-1:0] run_src[MAX_ITEMS];
		logic signed [DATA_WIDTH-1:0] run_dst[MAX_ITEMS];
		int width, lo, mid, hi, l, r, o;
		sorted_beat_t beat;
		run_src = set_values;
		run_dst = set_values;
		for (width = 1; width < set_count; width *= 2) begin
			for (lo = 0; lo < set_count; lo += 2 * width) begin
				mid = (lo + width > set_count) ? set_count : lo + width;
				hi  = (lo + 2 * width > set_count) ? set_count : lo + 2 * width;
				l   = lo;
				r   = mid;
				for (o = lo; o < hi; o++) begin
					if (r < hi && (l >= mid || run_src[r] > run_src[l])) begin
						run_dst[o] = run_src[r];
						r++;
					end else begin
						run_dst[o] = run_src[l];
						l++;
					end
				end
			end
			run_src = run_dst;
		end
		for (int k = 0; k < set_count; k++) begin
			beat.value    = run_src[k];
			beat.is_final = (k == set_count - 1);
			expected_sorted.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t want;
		if (!arst_n) begin
			set_count = 0;
			expected_sorted.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sorted.size() == 0) begin
					report_mismatch("result beat with nothing pending", sorted_value, 0);
				end else begin
					want = expected_sorted.pop_front();
					if (sorted_value !== want.value)
						report_mismatch("sorted_value", sorted_value, want.value);
					if (final_res !== want.is_final)
						report_mismatch("final_res", final_res, want.is_final);
				end
			end
			if (in_valid && in_ready) begin
				if (set_count < MAX_ITEMS) begin
					set_values[set_count] = in_value;
					set_count++;
				end
				if (in_last) begin
					queue_sorted_set();
					set_count = 0;
				end
			end
		end
		outstanding <= expected_sorted.size();
	end

endmodule

// ===== bench/tb.sv =====
// Top of the sort unit bench: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_ITEMS      = 64;
	localparam int DW             = 32;
	localparam int ITEM_TARGET    = 330;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 40;
	localparam int TIMEOUT_CYCLES = 400000;

	localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   stored_items;
	int   cycle_count;
	bit   source_quiet;
	bit   hold_request;

	msd_in_if  #(.DATA_WIDTH(DW)) items_ch ();
	msd_out_if #(.DATA_WIDTH(DW)) results_ch ();

	merge_sort_descending_unit #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch)
	);

	msd_sort_checker #(
		.MAX_ITEMS (MAX_ITEMS),
		.DATA_WIDTH(DW)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (items_ch.valid),
		.in_ready    (items_ch.ready),
		.in_value    (items_ch.value),
		.in_last     (items_ch.last),
		.out_valid   (results_ch.valid),
		.out_ready   (results_ch.ready),
		.sorted_value(results_ch.sorted_value),
		.final_res   (results_ch.final_res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("merge_sort_descending_unit verification failed");
			$finish;
		end
	end

	// Gap before a beat: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Value flavors: 0 full range, 1 tight range (many ties), 2 extremes, 3 mixed.
	function automatic logic signed [DW-1:0] pick_value(input int flavor);
		int f;
		f = (flavor == 3) ? $urandom_range(0, 2) : flavor;
		case (f)
			0: begin
				return $urandom;
			end
			1: begin
				return $signed($urandom_range(0, 6)) - 3;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return MAX_VAL;
					1: return MIN_VAL;
					2: return '0;
					3: return '1;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	// Offer one beat and hold it until the unit takes it. Keep valid high
	// across back-to-back beats; drop it only for a gap.
	task automatic send_beat(input logic signed [DW-1:0] v, input logic l);
		int gap;
		gap = source_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.value <= v;
		items_ch.last  <= l;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
	endtask

	// Send a whole set from a list; the final entry carries the last flag.
	task automatic send_set(input logic signed [DW-1:0] vals[$]);
		foreach (vals[i])
			send_beat(vals[i], i == vals.size() - 1);
		stored_items += (vals.size() > MAX_ITEMS) ? MAX_ITEMS : vals.size();
	endtask

	task automatic send_random_set(input int len);
		logic signed [DW-1:0] vals[$];
		int flavor;
		flavor = $urandom_range(0, 3);
		repeat (len) vals.push_back(pick_value(flavor));
		send_set(vals);
	endtask

	// Set length: mostly small, some medium, a few full, a few past capacity
	// so the count saturates and the extra beats are dropped.
	function automatic int pick_set_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 12);
		if (roll < 85)
			return $urandom_range(13, 40);
		if (roll < 93)
			return MAX_ITEMS;
		return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 10);
	endfunction

	// Result side: random stalls, quiet stretches, and one long hold-off on
	// request so the unit backs up into its input.
	initial begin
		int stall_left;
		int quiet_left;
		stall_left = 0;
		quiet_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet_left > 0) begin
				results_ch.ready <= 1'b1;
				quiet_left--;
			end else if (stall_left > 0) begin
				results_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				results_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < 2)
					quiet_left = $urandom_range(50, 150);
				else if ($urandom_range(0, 99) < 25)
					stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
			end
			@(posedge clk);
		end
	end

	initial begin
		logic signed [DW-1:0] vals[$];
		arst_n                = 1'b0;
		items_ch.valid        = 1'b0;
		items_ch.value        = '0;
		items_ch.last         = 1'b0;
		results_ch.ready      = 1'b0;
		stored_items          = 0;
		source_quiet          = 1'b0;
		hold_request          = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: a lone beat, the two extremes, mixed signs, ties,
		// already descending, and alternating bit patterns.
		vals = '{32'sd0};
		send_set(vals);
		vals = '{MIN_VAL, MAX_VAL};
		send_set(vals);
		vals = '{MAX_VAL, MIN_VAL, 32'sd0, -32'sd1, 32'sd1};
		send_set(vals);
		vals = '{32'sd5, 32'sd5, -32'sd5, -32'sd5, 32'sd5};
		send_set(vals);
		vals = '{32'sd100, 32'sd50, 32'sd0, -32'sd50, -32'sd100};
		send_set(vals);
		vals = '{32'sh5555_5555, 32'shaaaa_aaaa};
		send_set(vals);

		// Back the unit up: freeze the result side, then push a full set and
		// keep offering the next one while the sort output is stuck.
		hold_request = 1'b1;
		source_quiet = 1'b1;
		send_random_set(MAX_ITEMS);
		send_random_set(8);
		source_quiet = 1'b0;

		// Random sets until enough stored beats have gone in.
		while (stored_items < ITEM_TARGET) begin
			source_quiet = ($urandom_range(0, 99) < 15);
			send_random_set(pick_set_len());
		end
		items_ch.valid <= 1'b0;
		items_ch.last  <= 1'b0;

		// Let the checker queue the final set, drain every pending result,
		// then let the unit settle.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("merge_sort_descending_unit verification clean");
		else
			$display("merge_sort_descending_unit verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/msd_pkg.sv
hw/rtl/msd_in_if.sv
hw/rtl/msd_out_if.sv
hw/rtl/msd_mem.sv
hw/rtl/msd_engine.sv
hw/rtl/merge_sort_descending_unit.sv
bench/msd_sort_checker.sv
bench/tb.sv
